/* hw/rtl/csro_pkg.sv */
// shared types and constants for the colour sensor serial readout
`default_nettype none
package csro_pkg;

  localparam int BITS_PER_COLOR = 12;
  localparam int BIT_IDX_W      = $clog2(BITS_PER_COLOR);
  localparam int COLOR_W        = 12;
  localparam int NUM_COLORS     = 3;
  localparam int COLOR_IDX_W    = 2;
  localparam int TICK_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 3'd5;

  // register reset values
  localparam logic [TICK_W-1:0] PREP_RST      = 16'd5;
  localparam logic [TICK_W-1:0] INTEGRATE_RST = 16'd100;
  localparam logic [TICK_W-1:0] SETTLE_RST    = 16'd1;
  localparam logic [TICK_W-1:0] HALF_PER_RST  = 16'd1;
  localparam logic [TICK_W-1:0] HOLD_RST      = 16'd1;

  // held colour after reset
  localparam logic [COLOR_W-1:0] RED_RST   = 12'd10;
  localparam logic [COLOR_W-1:0] GREEN_RST = 12'd0;
  localparam logic [COLOR_W-1:0] BLUE_RST  = 12'd10;

  localparam logic [COLOR_IDX_W-1:0] COLOR_RED   = 2'd0;
  localparam logic [COLOR_IDX_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [COLOR_IDX_W-1:0] COLOR_BLUE  = 2'd2;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_PREP   = 8'b0000_0010,
    PH_INTEG  = 8'b0000_0100,
    PH_SETTLE = 8'b0000_1000,
    PH_CKHI   = 8'b0001_0000,
    PH_CKLO   = 8'b0010_0000,
    PH_HOLD   = 8'b0100_0000,
    PH_FINISH = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] prep_ticks;
    logic [TICK_W-1:0] integrate_ticks;
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] half_period_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic              range_high;
  } cfg_t;

  typedef struct packed {
    logic               led_on;
    logic               gate_out;
    logic               clock_out;
    logic               range_out;
    logic               busy_res;
    logic               done_res;
    logic [COLOR_W-1:0] red_value;
    logic [COLOR_W-1:0] green_value;
    logic [COLOR_W-1:0] blue_value;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/csro_ifs.sv */
// valid/ready channel interfaces for the tick input and the result output
`default_nettype none
interface csro_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic sensor_data;

  modport source (output valid, output start_req, output sensor_data, input ready);
  modport sink (input valid, input start_req, input sensor_data, output ready);
endinterface

interface csro_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_on;
  logic                        gate_out;
  logic                        clock_out;
  logic                        range_out;
  logic                        busy_res;
  logic                        done_res;
  logic [csro_pkg::COLOR_W-1:0] red_value;
  logic [csro_pkg::COLOR_W-1:0] green_value;
  logic [csro_pkg::COLOR_W-1:0] blue_value;

  modport source (
    output valid, output led_on, output gate_out, output clock_out, output range_out,
    output busy_res, output done_res, output red_value, output green_value,
    output blue_value, input ready
  );
  modport sink (
    input valid, input led_on, input gate_out, input clock_out, input range_out,
    input busy_res, input done_res, input red_value, input green_value,
    input blue_value, output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/color_sensor_serial_readout.sv */
// top level of the colour sensor serial readout sequencer
//
//   port group  dir  beat contents
//   in_ch       in   start_req, sensor_data (one beat per time tick)
//   out_ch      out  led_on, gate_out, clock_out, range_out, busy_res,
//                    done_res, red_value, green_value, blue_value
//   cfg_*       in   cfg_we, cfg_index, cfg_wdata (register write)
//
// one beat in and one beat out per cycle when both sides keep up
// a tick reaches the output through the input register, then the result register
// the sequencer state advances as a tick moves from the input to the result register
// rst_n (synchronous) restores register defaults, idle phase and held colour 10/0/10
// out_ch.ready low holds the result; the input register still takes one more beat
`default_nettype none
module color_sensor_serial_readout (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  csro_in_if.sink                              in_ch,
  csro_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [csro_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [csro_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  csro_pkg::cfg_t cfg;
  csro_pkg::res_t res;
  csro_pkg::res_t res_r;

  logic in_valid_r;
  logic in_start_r;
  logic in_data_r;
  logic out_valid_r;
  logic out_free;
  logic step_en;
  logic in_take;

  assign out_free = !out_valid_r || out_ch.ready;
  assign step_en  = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (step_en) begin
        in_valid_r <= 1'b0;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_start_r <= in_ch.start_req;
      in_data_r  <= in_ch.sensor_data;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  csro_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  csro_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .start_req   (in_start_r),
    .sensor_data (in_data_r),
    .cfg         (cfg),
    .res         (res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led_on      = res_r.led_on;
  assign out_ch.gate_out    = res_r.gate_out;
  assign out_ch.clock_out   = res_r.clock_out;
  assign out_ch.range_out   = res_r.range_out;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.red_value   = res_r.red_value;
  assign out_ch.green_value = res_r.green_value;
  assign out_ch.blue_value  = res_r.blue_value;

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted tick not held in input register");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("sequencer step produced no result beat");

endmodule
`default_nettype wire

/* hw/rtl/csro_cfg.sv */
// configuration register bank of the colour sensor readout
`default_nettype none
module csro_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [csro_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [csro_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output csro_pkg::cfg_t                          cfg
);

  csro_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prep_ticks        <= csro_pkg::PREP_RST;
      cfg_r.integrate_ticks   <= csro_pkg::INTEGRATE_RST;
      cfg_r.settle_ticks      <= csro_pkg::SETTLE_RST;
      cfg_r.half_period_ticks <= csro_pkg::HALF_PER_RST;
      cfg_r.hold_ticks        <= csro_pkg::HOLD_RST;
      cfg_r.range_high        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        csro_pkg::REG_PREP:      cfg_r.prep_ticks        <= cfg_wdata;
        csro_pkg::REG_INTEGRATE: cfg_r.integrate_ticks   <= cfg_wdata;
        csro_pkg::REG_SETTLE:    cfg_r.settle_ticks      <= cfg_wdata;
        csro_pkg::REG_HALF_PER:  cfg_r.half_period_ticks <= cfg_wdata;
        csro_pkg::REG_HOLD:      cfg_r.hold_ticks        <= cfg_wdata;
        csro_pkg::REG_RANGE:     cfg_r.range_high        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* hw/rtl/csro_core.sv */
// measurement sequencer: phase state, tick counter, serial capture and held colour
`default_nettype none
module csro_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic          start_req,
  input  wire logic          sensor_data,
  input  wire csro_pkg::cfg_t cfg,
  output csro_pkg::res_t     res
);

  localparam int TW = csro_pkg::TICK_W;
  localparam int BW = csro_pkg::BIT_IDX_W;
  localparam int CW = csro_pkg::COLOR_IDX_W;
  localparam int DW = csro_pkg::COLOR_W;
  localparam logic [BW-1:0] LAST_BIT = BW'(csro_pkg::BITS_PER_COLOR - 1);

  csro_pkg::phase_t phase_r, phase_nxt;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic [BW-1:0]    bit_r, bit_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [DW-1:0]    red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [csro_pkg::BITS_PER_COLOR-1:0] shift_r [csro_pkg::NUM_COLORS];

  logic [TW-1:0]    len, len_eff;
  logic             last;
  logic             sample_en;
  logic [BW-1:0]    wr_bit;
  logic [CW-1:0]    wr_col;
  logic             done, busy, gate, sclk;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    col_nxt   = col_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    done      = 1'b0;
    busy      = 1'b0;
    gate      = 1'b0;
    sclk      = 1'b0;
    sample_en = 1'b0;

    // finishing tick: latch colour, drop back to idle, may restart below
    if (phase_r == csro_pkg::PH_FINISH) begin
      red_nxt   = DW'(shift_r[0]);
      green_nxt = DW'(shift_r[1]);
      blue_nxt  = DW'(shift_r[2]);
      done      = 1'b1;
      phase_nxt = csro_pkg::PH_IDLE;
    end
    if (phase_nxt == csro_pkg::PH_IDLE && start_req) begin
      phase_nxt = csro_pkg::PH_PREP;
      tick_nxt  = '0;
      bit_nxt   = '0;
      col_nxt   = '0;
    end

    case (phase_nxt)
      csro_pkg::PH_PREP:   len = cfg.prep_ticks;
      csro_pkg::PH_INTEG:  len = cfg.integrate_ticks;
      csro_pkg::PH_SETTLE: len = cfg.settle_ticks;
      csro_pkg::PH_CKHI:   len = cfg.half_period_ticks;
      csro_pkg::PH_CKLO:   len = cfg.half_period_ticks;
      csro_pkg::PH_HOLD:   len = cfg.hold_ticks;
      default:             len = TW'(1);
    endcase
    len_eff = (len == '0) ? TW'(1) : len;
    last    = ({1'b0, tick_nxt} + (TW+1)'(1)) >= {1'b0, len_eff};

    wr_bit = bit_nxt;
    wr_col = (col_nxt == 2'd3) ? csro_pkg::COLOR_BLUE : col_nxt;

    if (phase_nxt != csro_pkg::PH_IDLE) begin
      busy      = 1'b1;
      gate      = (phase_nxt == csro_pkg::PH_INTEG);
      sclk      = (phase_nxt == csro_pkg::PH_CKHI);
      sample_en = (phase_nxt == csro_pkg::PH_CKHI) && last;
      if (!last) begin
        tick_nxt = tick_nxt + TW'(1);
      end else begin
        tick_nxt = '0;
        case (phase_nxt)
          csro_pkg::PH_PREP:   phase_nxt = csro_pkg::PH_INTEG;
          csro_pkg::PH_INTEG:  phase_nxt = csro_pkg::PH_SETTLE;
          csro_pkg::PH_SETTLE: phase_nxt = csro_pkg::PH_CKHI;
          csro_pkg::PH_CKHI:   phase_nxt = csro_pkg::PH_CKLO;
          csro_pkg::PH_CKLO: begin
            if (bit_nxt >= LAST_BIT) begin
              bit_nxt   = '0;
              phase_nxt = csro_pkg::PH_HOLD;
            end else begin
              bit_nxt   = bit_nxt + BW'(1);
              phase_nxt = csro_pkg::PH_CKHI;
            end
          end
          csro_pkg::PH_HOLD: begin
            if (col_nxt >= csro_pkg::COLOR_BLUE) begin
              col_nxt   = '0;
              phase_nxt = csro_pkg::PH_FINISH;
            end else begin
              col_nxt   = col_nxt + CW'(1);
              phase_nxt = csro_pkg::PH_CKHI;
            end
          end
          default: phase_nxt = csro_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csro_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      col_r   <= '0;
      red_r   <= csro_pkg::RED_RST;
      green_r <= csro_pkg::GREEN_RST;
      blue_r  <= csro_pkg::BLUE_RST;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      col_r   <= col_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // serial capture, one bit on the last tick of each clock-high phase
  always_ff @(posedge clk) begin
    if (step_en && sample_en) begin
      shift_r[wr_col][wr_bit] <= sensor_data;
    end
  end

  assign res.led_on      = busy;
  assign res.gate_out    = gate;
  assign res.clock_out   = sclk;
  assign res.range_out   = cfg.range_high;
  assign res.busy_res    = busy;
  assign res.done_res    = done;
  assign res.red_value   = red_nxt;
  assign res.green_value = green_nxt;
  assign res.blue_value  = blue_nxt;

  a_gate_clk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.gate_out && res.clock_out))
    else $error("gate and serial clock high together");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= LAST_BIT)
    else $error("bit index past end of word");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r != 2'd3)
    else $error("colour index out of range");

  // a restart with a one-tick preparation lands straight in integration
  a_finish_exit: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == csro_pkg::PH_FINISH |=>
      phase_r == csro_pkg::PH_IDLE || phase_r == csro_pkg::PH_PREP ||
      phase_r == csro_pkg::PH_INTEG)
    else $error("finishing tick not followed by idle or restart");

endmodule
`default_nettype wire

/* tb/sv/csro_checker.sv */
// checker for the colour sensor readout: predicts every result beat and compares it
module csro_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  csro_in_if                    in_mon,
  csro_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [csro_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csro_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import csro_pkg::*;

  // shadow copy of the sequencer
  cfg_t                      regs;
  phase_t                    cur_phase;
  logic [TICK_W-1:0]         tick_cnt;
  logic [3:0]                bit_idx;
  logic [COLOR_IDX_W-1:0]    color_idx;
  logic [BITS_PER_COLOR-1:0] shift_word [NUM_COLORS];
  logic [COLOR_W-1:0]        held_red, held_green, held_blue;

  res_t predicted_levels [$];
  int   mismatches = 0;

  assign fail_count = mismatches;
  assign pending    = predicted_levels.size();

  function automatic logic [TICK_W-1:0] phase_length(input phase_t ph);
    logic [TICK_W-1:0] len;
    case (ph)
      PH_PREP:          len = regs.prep_ticks;
      PH_INTEG:         len = regs.integrate_ticks;
      PH_SETTLE:        len = regs.settle_ticks;
      PH_CKHI, PH_CKLO: len = regs.half_period_ticks;
      PH_HOLD:          len = regs.hold_ticks;
      default:          len = TICK_W'(1);
    endcase
    // a length of zero runs as one tick
    return (len == '0) ? TICK_W'(1) : len;
  endfunction

  // advance the shadow sequencer by one tick and return the levels of that tick
  function automatic res_t step_sequencer(input logic start, input logic data);
    res_t r;
    logic last;
    int   c;
    r = '0;
    if (cur_phase == PH_FINISH) begin
      held_red   = shift_word[COLOR_RED][COLOR_W-1:0];
      held_green = shift_word[COLOR_GREEN][COLOR_W-1:0];
      held_blue  = shift_word[COLOR_BLUE][COLOR_W-1:0];
      r.done_res = 1'b1;
      cur_phase  = PH_IDLE;
    end
    if (cur_phase == PH_IDLE && start) begin
      cur_phase = PH_PREP;
      tick_cnt  = '0;
      bit_idx   = '0;
      color_idx = COLOR_RED;
    end
    if (cur_phase != PH_IDLE) begin
      last        = (int'(tick_cnt) + 1) >= int'(phase_length(cur_phase));
      r.busy_res  = 1'b1;
      r.led_on    = 1'b1;
      r.gate_out  = (cur_phase == PH_INTEG);
      r.clock_out = (cur_phase == PH_CKHI);
      // data bit is taken on the last tick of clock high
      if (cur_phase == PH_CKHI && last) begin
        c = (color_idx < NUM_COLORS) ? int'(color_idx) : int'(COLOR_BLUE);
        shift_word[c][bit_idx] = data;
      end
      if (!last) begin
        tick_cnt = tick_cnt + 1'b1;
      end else begin
        tick_cnt = '0;
        case (cur_phase)
          PH_PREP:   cur_phase = PH_INTEG;
          PH_INTEG:  cur_phase = PH_SETTLE;
          PH_SETTLE: cur_phase = PH_CKHI;
          PH_CKHI:   cur_phase = PH_CKLO;
          PH_CKLO: begin
            if (int'(bit_idx) + 1 >= BITS_PER_COLOR) begin
              bit_idx   = '0;
              cur_phase = PH_HOLD;
            end else begin
              bit_idx   = bit_idx + 1'b1;
              cur_phase = PH_CKHI;
            end
          end
          PH_HOLD: begin
            if (color_idx >= COLOR_BLUE) begin
              color_idx = COLOR_RED;
              cur_phase = PH_FINISH;
            end else begin
              color_idx = color_idx + 1'b1;
              cur_phase = PH_CKHI;
            end
          end
          default: cur_phase = PH_IDLE;
        endcase
      end
    end
    r.range_out   = regs.range_high;
    r.red_value   = held_red;
    r.green_value = held_green;
    r.blue_value  = held_blue;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs       = '{prep_ticks: PREP_RST, integrate_ticks: INTEGRATE_RST,
                     settle_ticks: SETTLE_RST, half_period_ticks: HALF_PER_RST,
                     hold_ticks: HOLD_RST, range_high: 1'b0};
      cur_phase  = PH_IDLE;
      tick_cnt   = '0;
      bit_idx    = '0;
      color_idx  = COLOR_RED;
      for (int i = 0; i < NUM_COLORS; i++) shift_word[i] = '0;
      held_red   = RED_RST;
      held_green = GREEN_RST;
      held_blue  = BLUE_RST;
      predicted_levels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PREP:      regs.prep_ticks        = cfg_wdata;
          REG_INTEGRATE: regs.integrate_ticks   = cfg_wdata;
          REG_SETTLE:    regs.settle_ticks      = cfg_wdata;
          REG_HALF_PER:  regs.half_period_ticks = cfg_wdata;
          REG_HOLD:      regs.hold_ticks        = cfg_wdata;
          REG_RANGE:     regs.range_high        = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predicted_levels.push_back(step_sequencer(in_mon.start_req, in_mon.sensor_data));
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_levels.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          want = predicted_levels.pop_front();
          check_field("led_on", want.led_on, out_mon.led_on);
          check_field("gate_out", want.gate_out, out_mon.gate_out);
          check_field("clock_out", want.clock_out, out_mon.clock_out);
          check_field("range_out", want.range_out, out_mon.range_out);
          check_field("busy_res", want.busy_res, out_mon.busy_res);
          check_field("done_res", want.done_res, out_mon.done_res);
          check_field("red_value", want.red_value, out_mon.red_value);
          check_field("green_value", want.green_value, out_mon.green_value);
          check_field("blue_value", want.blue_value, out_mon.blue_value);
        end
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
// testbench top: clock, reset, tick and register stimulus, result sink and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csro_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL     = 300;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  csro_in_if  in_ch ();
  csro_out_if out_ch ();

  color_sensor_serial_readout u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  csro_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  bit calm      = 1'b0;  // no idling on either side
  bit stall_req = 1'b0;  // asks the sink for one long hold-off
  bit chained   = 1'b0;  // last finish tick already started the next measurement
  int prep_n, integ_n, settle_n, half_n, hold_n;
  int items       = 0;
  int idle_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    else if (r < 19) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int eff(input logic [TICK_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic logic [BITS_PER_COLOR-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return BITS_PER_COLOR'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic start, input logic data);
    in_ch.valid       <= 1'b1;
    in_ch.start_req   <= start;
    in_ch.sensor_data <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [TICK_W-1:0] p, i, s, h, hd,
                              input logic [CFG_DATA_W-1:0] rng);
    cfg_write(REG_PREP, p);
    cfg_write(REG_INTEGRATE, i);
    cfg_write(REG_SETTLE, s);
    cfg_write(REG_HALF_PER, h);
    cfg_write(REG_HOLD, hd);
    cfg_write(REG_RANGE, rng);
    // unmapped indexes must be ignored
    cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
    cfg_write(REG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_we   <= 1'b0;
    prep_n   = eff(p);
    integ_n  = eff(i);
    settle_n = eff(s);
    half_n   = eff(h);
    hold_n   = eff(hd);
  endtask

  // one well-formed measurement; sensor_data carries the words on the clock-high ticks
  task automatic measure(input logic [BITS_PER_COLOR-1:0] r, g, b, input int chain_pct);
    logic [BITS_PER_COLOR-1:0] words [NUM_COLORS];
    int t;
    words[COLOR_RED]   = r;
    words[COLOR_GREEN] = g;
    words[COLOR_BLUE]  = b;
    if (!chained) send_tick(1'b1, rnd_bit());
    for (t = 1; t < prep_n; t++) send_tick(rnd_bit(), rnd_bit());
    repeat (integ_n + settle_n) send_tick(rnd_bit(), rnd_bit());
    for (int c = 0; c < NUM_COLORS; c++) begin
      for (int k = 0; k < BITS_PER_COLOR; k++) begin
        repeat (half_n) send_tick(rnd_bit(), words[c][k]);
        repeat (half_n) send_tick(rnd_bit(), rnd_bit());
      end
      repeat (hold_n) send_tick(rnd_bit(), rnd_bit());
    end
    // finishing tick, optionally starting the next measurement on it
    chained = ($urandom_range(0, 99) < chain_pct);
    send_tick(chained, rnd_bit());
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result sink with random hold-offs
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int target;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PREP;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.start_req   <= 1'b0;
    in_ch.sensor_data <= 1'b0;
    prep_n   = eff(PREP_RST);
    integ_n  = eff(INTEGRATE_RST);
    settle_n = eff(SETTLE_RST);
    half_n   = eff(HALF_PER_RST);
    hold_n   = eff(HOLD_RST);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // held colour and register defaults straight out of reset
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    measure(pick_word(), pick_word(), pick_word(), 0);
    wait_drained();

    // zero lengths run as one tick, range takes bit 0 only, restart on the finishing tick
    apply_config('0, '0, '0, '0, '0, 16'hFFFF);
    measure('1, '0, 12'h5A5, 100);
    measure('0, '1, 12'hA5A, 0);
    send_tick(1'b0, 1'b1);
    wait_drained();
    apply_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFE);
    measure(12'h001, 12'h800, 12'h7FE, 0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_config(TICK_W'($urandom_range(0, 6)), TICK_W'($urandom_range(0, 6)),
                   TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 2)),
                   TICK_W'($urandom_range(0, 4)), CFG_DATA_W'($urandom));
      // one long sink hold-off while ticks keep coming
      if (ph == 1) stall_req = 1'b1;
      target = items + PHASE_ITEMS;
      while (items < target) begin
        if (chained || $urandom_range(0, 3) != 0) begin
          measure(pick_word(), pick_word(), pick_word(), 30);
        end else begin
          repeat ($urandom_range(5, 40)) send_tick($urandom_range(0, 7) == 0, rnd_bit());
          // idle ticks until any stray measurement has finished
          repeat (prep_n + integ_n + settle_n + NUM_COLORS * (2 * BITS_PER_COLOR * half_n
                  + hold_n) + 2)
            send_tick(1'b0, rnd_bit());
        end
      end
      if (chained) measure(pick_word(), pick_word(), pick_word(), 0);
      wait_drained();
    end

    // longest clock phase, idle ticks only
    apply_config(16'd1, 16'd1, 16'd1, 16'hFFFF, 16'd1, 16'h0001);
    repeat (20) send_tick(1'b0, rnd_bit());
    wait_drained();

    // steady run with no idling on either side
    calm = 1'b1;
    apply_config(16'd3, 16'd7, 16'd2, 16'd1, 16'd2, 16'h8000);
    measure(pick_word(), pick_word(), pick_word(), 0);
    wait_drained();
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
